// ===== rtl/jts_pkg.sv =====
// Package with the types, constants and character classification of the JSON token scanner.
package jts_pkg;

	localparam int MaxDepth = 32;
	localparam int PosBits = 16;
	localparam int LvlBits = 6;
	localparam int MarkBits = $clog2(MaxDepth);
	localparam int QDepth = 2;
	localparam int QPtrBits = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntBits = $clog2(QDepth + 1);

	localparam logic [2:0] T_OBJ = 3'd0;
	localparam logic [2:0] T_ARR = 3'd1;
	localparam logic [2:0] T_NUM = 3'd2;
	localparam logic [2:0] T_STR = 3'd3;
	localparam logic [2:0] T_FLS = 3'd4;
	localparam logic [2:0] T_TRU = 3'd5;
	localparam logic [2:0] T_NUL = 3'd6;

	localparam logic [2:0] LenFalse = 3'd5;
	localparam logic [2:0] LenTrueNull = 3'd4;

	typedef enum logic [3:0] {
		PH_SEEK, PH_BETWEEN, PH_AFTER_COLON, PH_STRING, PH_STRING_ESC,
		PH_NUMBER, PH_LITERAL, PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		NS_MINUS, NS_NEED_DOT, NS_INT, NS_FRAC, NS_EXP, NS_SKIP_FRAC, NS_SKIP_EXP
	} numst_t;

	// Byte classes, worked out once by the front part.
	typedef struct packed {
		logic digit;
		logic digit19;
		logic ws;
		logic comma;
		logic close;
		logic colon;
		logic quote;
		logic bslash;
		logic dot;
		logic expo;
		logic minus;
		logic obrace;
		logic nul;
		logic tok_ok;
		logic [2:0] tok_type;
	} cls_t;

	// One classified item in the queue.
	typedef struct packed {
		cls_t cls;
		logic last;
		logic [PosBits-1:0] pos;
	} qent_t;

	typedef struct packed {
		logic [2:0] ttype;
		logic [LvlBits-1:0] depth;
		logic [PosBits-1:0] pos;
		logic is_end;
		logic err;
	} rec_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r = '0;
		r.digit = (c >= "0") && (c <= "9");
		r.digit19 = (c >= "1") && (c <= "9");
		r.ws = (c == " ") || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
		r.comma = (c == ",");
		r.close = (c == "}") || (c == "]");
		r.colon = (c == ":");
		r.quote = (c == 8'h22);
		r.bslash = (c == 8'h5c);
		r.dot = (c == ".");
		r.expo = (c == "e") || (c == "E");
		r.minus = (c == "-");
		r.obrace = (c == "{");
		r.nul = (c == 8'h00);
		r.tok_ok = 1'b1;
		if (r.digit || c == "+" || c == "-") r.tok_type = T_NUM;
		else if (r.quote) r.tok_type = T_STR;
		else if (c == "{") r.tok_type = T_OBJ;
		else if (c == "[") r.tok_type = T_ARR;
		else if (c == "f") r.tok_type = T_FLS;
		else if (c == "t") r.tok_type = T_TRU;
		else if (c == "n") r.tok_type = T_NUL;
		else r.tok_ok = 1'b0;
		return r;
	endfunction

endpackage

// ===== rtl/jts_front.sv =====
// Front part: takes bytes, classifies them, stamps positions and stops after the end.
module jts_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  stall,
	output logic                  q_push,
	output jts_pkg::qent_t        q_data,
	input  logic                  q_full
);
	import jts_pkg::*;

	logic [PosBits-1:0] pos_q;
	logic               ended_q;
	logic               take;

	// Once a NUL or last byte has gone through, later items are swallowed unrecorded.
	assign stall = q_full && !ended_q;
	assign take = valid && !stall;
	assign q_push = take && !ended_q;
	assign q_data = '{cls: classify(data_byte), last: last_byte, pos: pos_q};

	// Position counter and end mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ended_q <= 1'b0;
		end else if (q_push) begin
			pos_q <= pos_q + 1'b1;
			if (last_byte || data_byte == 8'h00) ended_q <= 1'b1;
		end
	end
endmodule

// ===== rtl/jts_queue.sv =====
// Short queue of classified items between the front and back parts.
module jts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jts_pkg::qent_t  wdata,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output jts_pkg::qent_t  rdata
);
	import jts_pkg::*;

	qent_t mem_q [QDepth];
	logic [QPtrBits-1:0] wp_q, rp_q;
	logic [QCntBits-1:0] cnt_q;

	assign full = (cnt_q == QCntBits'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == QPtrBits'(QDepth - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == QPtrBits'(QDepth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + QCntBits'(push) - QCntBits'(pop);
		end
	end
endmodule

// ===== rtl/jts_back.sv =====
// Back part: runs the scan state machine and the nesting stack, and holds the record register.
module jts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  jts_pkg::qent_t  q_data,
	output logic            q_pop,
	output logic            valid,
	input  logic            stall,
	output jts_pkg::rec_t   rec
);
	import jts_pkg::*;

	phase_t             ph_q, ph_d;
	numst_t             ns_q, ns_d;
	logic [2:0]         lit_q, lit_d;
	logic [MaxDepth-1:0] marks_q, marks_d;
	logic [LvlBits-1:0] lvl_q, lvl_d;
	logic [2:0]         prev_q, prev_d;
	logic               ovalid_q;
	rec_t               rec_q;
	logic               rv;
	rec_t               r;
	cls_t               c;
	logic               go_between, step;

	assign c = q_data.cls;
	assign valid = ovalid_q;
	assign rec = rec_q;
	assign step = q_valid && (!ovalid_q || !stall);
	assign q_pop = step;

	// Scan logic for one item.
	always_comb begin
		ph_d = ph_q;
		ns_d = ns_q;
		lit_d = lit_q;
		marks_d = marks_q;
		lvl_d = lvl_q;
		prev_d = prev_q;
		rv = 1'b0;
		r = '{ttype: T_OBJ, depth: '0, pos: q_data.pos, is_end: 1'b0, err: 1'b0};
		go_between = 1'b0;
		if (ph_q == PH_DONE) begin
			ph_d = PH_DONE;
		end else if (c.nul) begin
			rv = 1'b1;
			r.is_end = 1'b1;
			ph_d = PH_DONE;
		end else begin
			case (ph_q)
				PH_SEEK: begin
					if (c.obrace) begin
						rv = 1'b1;
						marks_d[0] = 1'b0;
						lvl_d = LvlBits'(1);
						prev_d = T_OBJ;
						ph_d = PH_BETWEEN;
					end
				end
				PH_BETWEEN: go_between = 1'b1;
				PH_AFTER_COLON: begin
					if (!c.ws) begin
						go_between = 1'b1;
					end
				end
				PH_STRING: begin
					if (c.bslash) ph_d = PH_STRING_ESC;
					else if (c.quote) ph_d = PH_BETWEEN;
				end
				PH_STRING_ESC: ph_d = PH_STRING;
				PH_NUMBER: begin
					case (ns_q)
						NS_MINUS: ns_d = c.digit19 ? NS_INT : NS_NEED_DOT;
						NS_SKIP_FRAC: ns_d = NS_FRAC;
						NS_SKIP_EXP: ns_d = NS_EXP;
						default: begin
							if ((ns_q == NS_INT || ns_q == NS_FRAC || ns_q == NS_EXP)
								&& c.digit) begin
								ns_d = ns_q;
							end else if ((ns_q == NS_NEED_DOT || ns_q == NS_INT) && c.dot) begin
								ns_d = NS_SKIP_FRAC;
							end else if ((ns_q == NS_NEED_DOT || ns_q == NS_INT
								|| ns_q == NS_FRAC) && c.expo) begin
								ns_d = NS_SKIP_EXP;
							end else begin
								ns_d = NS_MINUS;
								ph_d = PH_BETWEEN;
								go_between = 1'b1;
							end
						end
					endcase
				end
				PH_LITERAL: begin
					if (lit_q > 3'd0) lit_d = lit_q - 3'd1;
					if (lit_d == 3'd0) ph_d = PH_BETWEEN;
				end
				default: ph_d = PH_DONE;
			endcase
			// Between tokens; after a colon, white space is skipped and anything that is not a token start is an error.
			if (go_between) begin
				if (ph_q != PH_AFTER_COLON && (c.comma || c.ws)) begin
					ph_d = ph_d;
				end else if (ph_q != PH_AFTER_COLON && c.close) begin
					if (lvl_q <= LvlBits'(1)) begin
						lvl_d = '0;
						rv = 1'b1;
						r.is_end = 1'b1;
						ph_d = PH_DONE;
					end else if (marks_q[MarkBits'(lvl_q - LvlBits'(2))]) begin
						lvl_d = lvl_q - LvlBits'(2);
					end else begin
						lvl_d = lvl_q - LvlBits'(1);
					end
				end else if (ph_q != PH_AFTER_COLON && c.colon) begin
					if (prev_q != T_STR || lvl_q >= LvlBits'(MaxDepth)) begin
						rv = 1'b1;
						r.err = 1'b1;
						r.depth = lvl_q;
						ph_d = PH_DONE;
					end else begin
						marks_d[lvl_q[MarkBits-1:0]] = 1'b1;
						lvl_d = lvl_q + LvlBits'(1);
						ph_d = PH_AFTER_COLON;
					end
				end else if (!c.tok_ok || ((c.tok_type == T_OBJ || c.tok_type == T_ARR)
					&& lvl_q >= LvlBits'(MaxDepth))) begin
					rv = 1'b1;
					r.err = 1'b1;
					r.depth = lvl_q;
					ph_d = PH_DONE;
				end else begin
					rv = 1'b1;
					r.ttype = c.tok_type;
					r.depth = lvl_q;
					prev_d = c.tok_type;
					if (c.tok_type == T_OBJ || c.tok_type == T_ARR) begin
						marks_d[lvl_q[MarkBits-1:0]] = 1'b0;
						lvl_d = lvl_q + LvlBits'(1);
						ph_d = PH_BETWEEN;
					end else begin
						if (lvl_q != '0 && marks_q[MarkBits'(lvl_q - LvlBits'(1))]) begin
							lvl_d = lvl_q - LvlBits'(1);
						end
						if (c.tok_type == T_STR) begin
							ph_d = PH_STRING;
						end else if (c.tok_type == T_NUM) begin
							ph_d = PH_NUMBER;
							ns_d = c.minus ? NS_MINUS : NS_INT;
						end else begin
							ph_d = PH_LITERAL;
							lit_d = ((c.tok_type == T_FLS) ? LenFalse : LenTrueNull) - 3'd1;
						end
					end
				end
			end
		end
		if (ph_q != PH_DONE && q_data.last) begin
			if (!rv) begin
				r = '{ttype: T_OBJ, depth: '0, pos: q_data.pos, is_end: 1'b1, err: 1'b0};
			end
			rv = 1'b1;
			r.is_end = 1'b1;
			ph_d = PH_DONE;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_SEEK;
			ns_q <= NS_MINUS;
			lit_q <= 3'd0;
			marks_q <= '0;
			lvl_q <= LvlBits'(1);
			prev_q <= T_OBJ;
			ovalid_q <= 1'b0;
		end else begin
			if (step) begin
				ph_q <= ph_d;
				ns_q <= ns_d;
				lit_q <= lit_d;
				marks_q <= marks_d;
				lvl_q <= lvl_d;
				prev_q <= prev_d;
			end
			if (step) ovalid_q <= rv;
			else if (!stall) ovalid_q <= 1'b0;
		end
	end

	// Record register.
	always_ff @(posedge clk) begin
		if (step && rv) rec_q <= r;
	end
endmodule

// ===== rtl/json_token_scanner.sv =====
// Top level of the JSON token scanner: front classifier, item queue and back scanner.
//   channel | direction | handshake          | payload
//   in      | into      | in_valid/in_stall   | data_byte, last_byte
//   out     | out of    | out_valid/out_stall | token_type, token_depth, token_position,
//           |           |                     | is_end, error_flag
// One byte is taken per cycle while in_stall is low; its item is queued, then registered.
// While out_stall is low, the back state machine handles one queued item per cycle.
// Reset clears the scan state and the nesting stack at once; no clearing pass is needed.
// A stall on the output fills the two entry queue, then the input is stalled.
module json_token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_type,
	output logic [5:0]  token_depth,
	output logic [15:0] token_position,
	output logic        is_end,
	output logic        error_flag
);
	import jts_pkg::*;

	logic  push, full, pop, nempty;
	qent_t wdata, rdata;
	rec_t  rec;

	jts_front u_front (.clk, .arst_n, .valid(in_valid), .data_byte, .last_byte,
		.stall(in_stall), .q_push(push), .q_data(wdata), .q_full(full));
	jts_queue u_queue (.clk, .arst_n, .push, .wdata, .full, .pop,
		.not_empty(nempty), .rdata);
	jts_back u_back (.clk, .arst_n, .q_valid(nempty), .q_data(rdata), .q_pop(pop),
		.valid(out_valid), .stall(out_stall), .rec);

	assign token_type = rec.ttype;
	assign token_depth = rec.depth;
	assign token_position = rec.pos;
	assign is_end = rec.is_end;
	assign error_flag = rec.err;

	// The queue is never popped when empty nor pushed when full.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> nempty)
		else $error("queue popped while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue pushed while full");
	// A record with an error never also carries a token type other than object.
	a_err_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_flag) |-> (token_type == T_OBJ))
		else $error("error record with token type");
endmodule
